// File: sv/crpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_pkg
// Shared widths, register indexes, side-band type and a saturation helper for the
// camera rotate / perspective project unit.
// ----------------------------------------------------------------------------
package crpp_pkg;

    localparam int COORD_W = 32;
    localparam int TRIG_W  = 16;
    localparam int UQ_W    = 16;
    localparam int CTR_W   = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // divider geometry: positive denominator, numerator magnitude, quotient bits
    localparam int DEN_W = 48;
    localparam int MAG_W = 64;
    localparam int Q_W   = 34;
    localparam int CMP_W = DEN_W + Q_W;

    localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_YAW    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_SCALE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 4'd7;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic x_pos;
        logic x_neg;
        logic y_pos;
        logic y_neg;
        logic fault;
        logic ovf_x;
        logic ovf_y;
    } side_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [36:0] v);
        logic [COORD_W-1:0] r;
        if (v > 37'sh0_7FFF_FFFF)
            r = SAT_MAX;
        else if (v < -37'sh0_8000_0000)
            r = SAT_MIN;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/crpp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_div
// Pipelined restoring divider for both screen axes: one overflow check
// stage, then one quotient bit per stage, sharing the denominator.
// ----------------------------------------------------------------------------
module crpp_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_vld,
    input  wire logic [crpp_pkg::DEN_W-1:0]    den,
    input  wire logic [crpp_pkg::MAG_W-1:0]    mag_x,
    input  wire logic [crpp_pkg::MAG_W-1:0]    mag_y,
    input  wire crpp_pkg::side_t               side_in,
    output logic                               out_vld,
    output logic [crpp_pkg::Q_W-1:0]           quot_x,
    output logic [crpp_pkg::Q_W-1:0]           quot_y,
    output crpp_pkg::side_t                    side_out
);

    localparam int QW = crpp_pkg::Q_W;
    localparam int CW = crpp_pkg::CMP_W;
    localparam int MW = crpp_pkg::MAG_W;
    localparam int DW = crpp_pkg::DEN_W;

    logic                vld_reg  [0:QW];
    logic [DW-1:0]       den_reg  [0:QW];
    logic [MW-1:0]       rx_reg   [0:QW];
    logic [MW-1:0]       ry_reg   [0:QW];
    logic [QW-1:0]       qx_reg   [0:QW];
    logic [QW-1:0]       qy_reg   [0:QW];
    crpp_pkg::side_t     side_reg [0:QW];

    logic [CW-1:0] den_top;
    logic          ovf_x_next;
    logic          ovf_y_next;

    // quotient would need more than QW bits: saturate downstream
    assign den_top    = {den, {QW{1'b0}}};
    assign ovf_x_next = {{(CW-MW){1'b0}}, mag_x} >= den_top;
    assign ovf_y_next = {{(CW-MW){1'b0}}, mag_y} >= den_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= den;
            rx_reg[0]   <= mag_x;
            ry_reg[0]   <= mag_y;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            side_reg[0] <= '{x_pos: side_in.x_pos, x_neg: side_in.x_neg,
                             y_pos: side_in.y_pos, y_neg: side_in.y_neg,
                             fault: side_in.fault, ovf_x: ovf_x_next,
                             ovf_y: ovf_y_next};
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int BIT = QW - k;
        logic [CW-1:0] dsh;
        logic [CW-1:0] rxw;
        logic [CW-1:0] ryw;
        logic          take_x;
        logic          take_y;
        logic [CW-1:0] dif_x;
        logic [CW-1:0] dif_y;

        assign dsh    = {{QW{1'b0}}, den_reg[k-1]} << BIT;
        assign rxw    = {{(CW-MW){1'b0}}, rx_reg[k-1]};
        assign ryw    = {{(CW-MW){1'b0}}, ry_reg[k-1]};
        assign take_x = rxw >= dsh;
        assign take_y = ryw >= dsh;
        assign dif_x  = rxw - dsh;
        assign dif_y  = ryw - dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                rx_reg[k]   <= take_x ? dif_x[MW-1:0] : rx_reg[k-1];
                ry_reg[k]   <= take_y ? dif_y[MW-1:0] : ry_reg[k-1];
                qx_reg[k]   <= qx_reg[k-1] | ({{(QW-1){1'b0}}, take_x} << BIT);
                qy_reg[k]   <= qy_reg[k-1] | ({{(QW-1){1'b0}}, take_y} << BIT);
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign quot_x   = qx_reg[QW];
    assign quot_y   = qy_reg[QW];
    assign side_out = side_reg[QW];

`ifndef SYNTHESIS
    a_vld_advance: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[0] |=> vld_reg[1])
        else $error("divider lost an item between stages");
    a_ovf_quot: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW] && !side_reg[QW].fault && den_reg[QW] != '0
        |-> rx_reg[QW] < {{(MW-DW){1'b0}}, den_reg[QW]} || side_reg[QW].ovf_x)
        else $error("divider remainder not below denominator");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(qx_reg[QW]) && $stable(vld_reg[QW]))
        else $error("divider output moved while held");
`endif

endmodule
`default_nettype wire

// File: sv/camera_rotate_perspective_project_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// camera_rotate_perspective_project_unit
// Rotates a world point by camera yaw and pitch and projects it to screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries world_x/y/z (signed Q16.16).
//   Output channel out_valid / out_stall carries screen_x/y (signed Q16.16,
//   saturated) and depth_fault. An item moves at an edge where valid is high
//   and stall is low.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0..7);
//   other indexes are ignored. Write only while no item is in flight.
//   Throughput: one item per cycle while out_stall does not hold the pipeline.
//   Path from acceptance to out_valid: rotation and projection stages, the
//   34-stage quotient pipeline of the divider, and the output stage.
//   Stalls: the whole pipeline holds while the output register is full and
//   out_stall is high; in_stall then goes high. Nothing is lost or repeated.
//   Reset: all valid bits clear, registers return to identity rotation,
//   zoom and scale 1.0, center 0.
// ----------------------------------------------------------------------------
module camera_rotate_perspective_project_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [crpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [crpp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [crpp_pkg::COORD_W-1:0]   world_x,
    input  wire logic signed [crpp_pkg::COORD_W-1:0]   world_y,
    input  wire logic signed [crpp_pkg::COORD_W-1:0]   world_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [crpp_pkg::COORD_W-1:0]        screen_x,
    output logic signed [crpp_pkg::COORD_W-1:0]        screen_y,
    output logic                                       depth_fault
);

    logic signed [15:0] cos_pitch_reg, sin_pitch_reg, cos_yaw_reg, sin_yaw_reg;
    logic [15:0]        zoom_reg, view_scale_reg;
    logic [12:0]        center_x_reg, center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_pitch_reg  <= 16'sd16384;
            sin_pitch_reg  <= '0;
            cos_yaw_reg    <= 16'sd16384;
            sin_yaw_reg    <= '0;
            zoom_reg       <= 16'd256;
            view_scale_reg <= 16'd256;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crpp_pkg::REG_COS_PITCH:  cos_pitch_reg  <= cfg_data;
                crpp_pkg::REG_SIN_PITCH:  sin_pitch_reg  <= cfg_data;
                crpp_pkg::REG_COS_YAW:    cos_yaw_reg    <= cfg_data;
                crpp_pkg::REG_SIN_YAW:    sin_yaw_reg    <= cfg_data;
                crpp_pkg::REG_ZOOM:       zoom_reg       <= cfg_data;
                crpp_pkg::REG_VIEW_SCALE: view_scale_reg <= cfg_data;
                crpp_pkg::REG_CENTER_X:   center_x_reg   <= cfg_data[12:0];
                crpp_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;

    // advance everything when the output slot is free or being taken
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---- stage 1: yaw products and pitch products of y
    logic s1_vld_reg;
    logic signed [47:0] s1_xc_reg, s1_zs_reg, s1_xs_reg, s1_zc_reg, s1_yc_reg, s1_ys_reg;

    // ---- stage 2: x1, z1
    logic s2_vld_reg;
    logic signed [34:0] s2_x1_reg, s2_z1_reg;
    logic signed [47:0] s2_yc_reg, s2_ys_reg;
    logic signed [48:0] yaw_a, yaw_b;

    // ---- stage 3: z1 pitch products
    logic s3_vld_reg;
    logic signed [34:0] s3_x1_reg;
    logic signed [50:0] s3_zs_reg, s3_zc_reg;
    logic signed [47:0] s3_yc_reg, s3_ys_reg;

    // ---- stage 4: y2, z2
    logic s4_vld_reg;
    logic signed [34:0] s4_x1_reg;
    logic signed [37:0] s4_y2_reg, s4_z2_reg;
    logic signed [51:0] pit_a, pit_b;

    // ---- stage 5: zoom and scale products
    logic s5_vld_reg;
    logic signed [54:0] s5_zz_reg;
    logic signed [51:0] s5_xv_reg;
    logic signed [54:0] s5_yv_reg;
    crpp_pkg::side_t    s5_side_reg;

    // ---- stage 6: denominator and numerators
    logic s6_vld_reg;
    logic signed [47:0] s6_den_reg;
    logic signed [63:0] s6_nx_reg, s6_ny_reg;
    crpp_pkg::side_t    s6_side_reg;

    // ---- stage 7: fault and magnitudes
    logic s7_vld_reg;
    logic [crpp_pkg::DEN_W-1:0] s7_den_reg;
    logic [crpp_pkg::MAG_W-1:0] s7_mx_reg, s7_my_reg;
    crpp_pkg::side_t            s7_side_reg;

    always_comb
    begin
        yaw_a = s1_xc_reg - s1_zs_reg;
        yaw_b = s1_xs_reg + s1_zc_reg;
        pit_a = s3_yc_reg - s3_zs_reg;
        pit_b = s3_ys_reg + s3_zc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xc_reg <= world_x * cos_yaw_reg;
            s1_zs_reg <= world_z * sin_yaw_reg;
            s1_xs_reg <= world_x * sin_yaw_reg;
            s1_zc_reg <= world_z * cos_yaw_reg;
            s1_yc_reg <= world_y * cos_pitch_reg;
            s1_ys_reg <= world_y * sin_pitch_reg;

            s2_x1_reg <= yaw_a[48:14];
            s2_z1_reg <= yaw_b[48:14];
            s2_yc_reg <= s1_yc_reg;
            s2_ys_reg <= s1_ys_reg;

            s3_x1_reg <= s2_x1_reg;
            s3_zs_reg <= s2_z1_reg * sin_pitch_reg;
            s3_zc_reg <= s2_z1_reg * cos_pitch_reg;
            s3_yc_reg <= s2_yc_reg;
            s3_ys_reg <= s2_ys_reg;

            s4_x1_reg <= s3_x1_reg;
            s4_y2_reg <= pit_a[51:14];
            s4_z2_reg <= pit_b[51:14];

            s5_zz_reg <= s4_z2_reg * $signed({1'b0, zoom_reg});
            s5_xv_reg <= s4_x1_reg * $signed({1'b0, view_scale_reg});
            s5_yv_reg <= s4_y2_reg * $signed({1'b0, view_scale_reg});
            s5_side_reg <= '{x_pos: !s4_x1_reg[34] && s4_x1_reg != '0,
                             x_neg: s4_x1_reg[34],
                             y_pos: !s4_y2_reg[37] && s4_y2_reg != '0,
                             y_neg: s4_y2_reg[37],
                             fault: 1'b0, ovf_x: 1'b0, ovf_y: 1'b0};

            // den = 2.0 + floor(z2*zoom / 2^8), Q16.16
            s6_den_reg  <= {s5_zz_reg[54], s5_zz_reg[54:8]} + 48'sd131072;
            s6_nx_reg   <= {{3{s5_xv_reg[51]}}, s5_xv_reg, 9'b0};
            s6_ny_reg   <= {s5_yv_reg, 9'b0};
            s6_side_reg <= s5_side_reg;

            s7_den_reg  <= s6_den_reg;
            s7_mx_reg   <= s6_nx_reg[63] ? 64'(-s6_nx_reg) : s6_nx_reg;
            s7_my_reg   <= s6_ny_reg[63] ? 64'(-s6_ny_reg) : s6_ny_reg;
            s7_side_reg <= '{x_pos: s6_side_reg.x_pos, x_neg: s6_side_reg.x_neg,
                             y_pos: s6_side_reg.y_pos, y_neg: s6_side_reg.y_neg,
                             fault: s6_den_reg[47] || s6_den_reg == '0,
                             ovf_x: 1'b0, ovf_y: 1'b0};
        end
    end

    logic                     dv_vld;
    logic [crpp_pkg::Q_W-1:0] dv_qx, dv_qy;
    crpp_pkg::side_t          dv_side;

    crpp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s7_vld_reg),
        .den      (s7_den_reg),
        .mag_x    (s7_mx_reg),
        .mag_y    (s7_my_reg),
        .side_in  (s7_side_reg),
        .out_vld  (dv_vld),
        .quot_x   (dv_qx),
        .quot_y   (dv_qy),
        .side_out (dv_side)
    );

    // ---- output stage: sign, center offset, saturation
    logic signed [34:0] px, py;
    logic signed [36:0] cxs, cys, sum_x, sum_y;
    logic [31:0]        sx_next, sy_next;
    logic [31:0]        sx_reg, sy_reg;
    logic               fault_reg;

    always_comb
    begin
        px    = dv_side.x_neg ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
        py    = dv_side.y_neg ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
        cxs   = $signed({8'b0, center_x_reg, 16'b0});
        cys   = $signed({8'b0, center_y_reg, 16'b0});
        sum_x = cxs + {{2{px[34]}}, px};
        sum_y = cys - {{2{py[34]}}, py};
        priority if (dv_side.fault)
        begin
            sx_next = dv_side.x_pos ? crpp_pkg::SAT_MAX :
                      dv_side.x_neg ? crpp_pkg::SAT_MIN : cxs[31:0];
            sy_next = dv_side.y_pos ? crpp_pkg::SAT_MIN :
                      dv_side.y_neg ? crpp_pkg::SAT_MAX : cys[31:0];
        end
        else
        begin
            sx_next = dv_side.ovf_x ? (dv_side.x_neg ? crpp_pkg::SAT_MIN : crpp_pkg::SAT_MAX)
                                    : crpp_pkg::sat32(sum_x);
            sy_next = dv_side.ovf_y ? (dv_side.y_neg ? crpp_pkg::SAT_MAX : crpp_pkg::SAT_MIN)
                                    : crpp_pkg::sat32(sum_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            fault_reg <= dv_side.fault;
        end
    end

    assign out_valid   = out_valid_reg;
    assign screen_x    = sx_reg;
    assign screen_y    = sy_reg;
    assign depth_fault = fault_reg;

`ifndef SYNTHESIS
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty output register");
    a_fault_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && depth_fault |-> screen_x == crpp_pkg::SAT_MAX
        || screen_x == crpp_pkg::SAT_MIN || screen_x == {3'b0, center_x_reg, 16'b0})
        else $error("faulted item with unexpected screen_x");
    a_s1_move: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_vld_reg |=> s2_vld_reg)
        else $error("item lost between rotation stages");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives world points through the rotate / project unit, predicts each
// screen point in fixed point and checks results in order under random
// valid gaps, output stalls, a long output hold-off and register changes.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               fault;
    } screen_pt_t;

    class projection_board;
        logic signed [63:0] cos_p, sin_p, cos_y, sin_y;
        logic signed [63:0] zoom_r, scale_r, cx_r, cy_r;
        screen_pt_t pending[$];
        int errors;

        function void reset_regs();
            cos_p = 16384; sin_p = 0; cos_y = 16384; sin_y = 0;
            zoom_r = 256; scale_r = 256; cx_r = 0; cy_r = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [crpp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
            case (idx)
                crpp_pkg::REG_COS_PITCH:  cos_p = $signed(d);
                crpp_pkg::REG_SIN_PITCH:  sin_p = $signed(d);
                crpp_pkg::REG_COS_YAW:    cos_y = $signed(d);
                crpp_pkg::REG_SIN_YAW:    sin_y = $signed(d);
                crpp_pkg::REG_ZOOM:       zoom_r = {48'd0, d};
                crpp_pkg::REG_VIEW_SCALE: scale_r = {48'd0, d};
                crpp_pkg::REG_CENTER_X:   cx_r = {51'd0, d[12:0]};
                crpp_pkg::REG_CENTER_Y:   cy_r = {51'd0, d[12:0]};
                default: ;
            endcase
        endfunction

        // >>> on signed values is an arithmetic shift, i.e. floor division
        function void note_point(logic signed [31:0] wx, logic signed [31:0] wy,
                                 logic signed [31:0] wz);
            logic signed [127:0] x, y, z, x1, z1, y2, z2, den, cx, cy, px, py, sx, sy;
            screen_pt_t r;
            x = wx; y = wy; z = wz;
            x1 = (x * cos_y - z * sin_y) >>> 14;
            z1 = (x * sin_y + z * cos_y) >>> 14;
            y2 = (y * cos_p - z1 * sin_p) >>> 14;
            z2 = (y * sin_p + z1 * cos_p) >>> 14;
            den = 128'sd131072 + ((z2 * zoom_r) >>> 8);
            cx = cx_r * 65536;
            cy = cy_r * 65536;
            r.fault = (den <= 0);
            if (r.fault)
            begin
                sx = x1 > 0 ? 128'sh7FFF_FFFF : (x1 < 0 ? -128'sh8000_0000 : cx);
                sy = y2 > 0 ? -128'sh8000_0000 : (y2 < 0 ? 128'sh7FFF_FFFF : cy);
            end
            else
            begin
                px = (x1 * scale_r * 512) / den;
                py = (y2 * scale_r * 512) / den;
                sx = cx + px;
                sy = cy - py;
                if (sx > 128'sh7FFF_FFFF) sx = 128'sh7FFF_FFFF;
                if (sx < -128'sh8000_0000) sx = -128'sh8000_0000;
                if (sy > 128'sh7FFF_FFFF) sy = 128'sh7FFF_FFFF;
                if (sy < -128'sh8000_0000) sy = -128'sh8000_0000;
            end
            r.sx = sx[31:0];
            r.sy = sy[31:0];
            pending.push_back(r);
        endfunction

        function void check_point(logic signed [31:0] sx, logic signed [31:0] sy,
                                  logic f);
            screen_pt_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h fault=%b", $time, sx, sy, f);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (sx !== e.sx)
            begin
                $display("%0t: screen_x expected %h actual %h", $time, e.sx, sx);
                errors++;
            end
            if (sy !== e.sy)
            begin
                $display("%0t: screen_y expected %h actual %h", $time, e.sy, sy);
                errors++;
            end
            if (f !== e.fault)
            begin
                $display("%0t: depth_fault expected %b actual %b", $time, e.fault, f);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_we;
    logic [crpp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [crpp_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall, depth_fault;
    logic signed [31:0] world_x, world_y, world_z, screen_x, screen_y;

    projection_board board;
    bit quiet;
    bit long_hold;
    int hold_cycles;

    camera_rotate_perspective_project_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_x(screen_x), .screen_y(screen_y), .depth_fault(depth_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 2 ** 24)) - (2 ** 23);
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off, none when quiet
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_point(screen_x, screen_y, depth_fault);
        if (long_hold)
            out_stall <= 1'b1;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            hold_cycles <= $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_cfg(logic [crpp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        world_x <= x;
        world_y <= y;
        world_z <= z;
        do @(posedge clk); while (in_stall);
        board.note_point(x, y, z);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic random_trig();
        write_cfg(crpp_pkg::REG_COS_PITCH, 16'($urandom_range(0, 32768) - 16384));
        write_cfg(crpp_pkg::REG_SIN_PITCH, 16'($urandom_range(0, 32768) - 16384));
        write_cfg(crpp_pkg::REG_COS_YAW, 16'($urandom_range(0, 32768) - 16384));
        write_cfg(crpp_pkg::REG_SIN_YAW, 16'($urandom_range(0, 32768) - 16384));
    endtask

    initial
    begin
        board = new();
        board.reset_regs();
        quiet = 1'b0;
        long_hold = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; out_stall = 1'b0;
        world_x = '0; world_y = '0; world_z = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes and zero
        send_point(0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000);  // den zero
        send_point(32'hFFFF_0000, 32'h0001_0000, 32'hFFF0_0000);  // den negative
        send_point(0, 0, 32'hFFF0_0000);                         // fault, on center
        drain();

        // zoom zero, large scale and trig beyond range, saturation
        write_cfg(crpp_pkg::REG_ZOOM, 16'd0);
        write_cfg(crpp_pkg::REG_VIEW_SCALE, 16'hFFFF);
        write_cfg(crpp_pkg::REG_CENTER_X, 16'h1FFF);
        write_cfg(crpp_pkg::REG_CENTER_Y, 16'hFFFF);
        write_cfg(crpp_pkg::REG_COS_YAW, 16'h7FFF);
        write_cfg(crpp_pkg::REG_SIN_YAW, 16'h8000);
        write_cfg(crpp_pkg::REG_COS_PITCH, 16'hC000);
        write_cfg(crpp_pkg::REG_SIN_PITCH, 16'h4000);
        write_cfg(4'd12, 16'h1234);  // ignored index
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_point(32'h0100_0000, 32'hFF00_0000, 32'h8000_0000);
        send_point(0, 32'h0000_0001, 32'hFFFF_FFFF);
        drain();

        write_cfg(crpp_pkg::REG_ZOOM, 16'hFFFF);
        write_cfg(crpp_pkg::REG_VIEW_SCALE, 16'd0);
        write_cfg(crpp_pkg::REG_CENTER_X, 16'd0);
        write_cfg(crpp_pkg::REG_CENTER_Y, 16'd0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        drain();

        // long receiver hold-off while the sender keeps offering items
        fork
            begin
                long_hold <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 80; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        drain();

        for (int p = 0; p < 8; p++)
        begin
            random_trig();
            write_cfg(crpp_pkg::REG_ZOOM,
                      p == 0 ? 16'd0 : (p == 1 ? 16'hFFFF : 16'($urandom_range(0, 1024))));
            write_cfg(crpp_pkg::REG_VIEW_SCALE,
                      p == 2 ? 16'hFFFF : 16'($urandom_range(0, 2048)));
            write_cfg(crpp_pkg::REG_CENTER_X,
                      p == 3 ? 16'h1FFF : 16'($urandom_range(0, 8191)));
            write_cfg(crpp_pkg::REG_CENTER_Y,
                      p == 3 ? 16'h1FFF : 16'($urandom_range(0, 8191)));
            if (p == 7)
                quiet = 1'b1;
            for (int i = 0; i < 95; i++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
